@@ src/lbc_pkg.sv @@
package lbc_pkg;

   localparam int MaxEntries    = 64;
   localparam int BlockWords    = 32;
   localparam int EntryW        = $clog2(MaxEntries);
   localparam int WordIdxW      = $clog2(BlockWords);
   localparam int StoreAddrW    = EntryW + WordIdxW;
   localparam int StageCntW     = $clog2(BlockWords + 1);
   localparam int EntriesCfgW   = 7;
   localparam int KeyW          = 12;
   localparam int StampW        = 32;
   localparam int DataW         = 64;
   localparam int MinEntries    = 2;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_MISS    = 2'd1,
      ST_PRESENT = 2'd2,
      ST_OFF     = 2'd3
   } status_type;

   localparam logic CSR_ENABLE  = 1'b0;
   localparam logic CSR_ENTRIES = 1'b1;

   typedef struct packed {
      logic       stage_wr;
      logic       stage_clr;
      logic       key_load;
      logic       scan_start;
      logic       scan_next;
      logic       scan_rd;
      logic       track;
      logic       tgt_cur;
      logic       tgt_old;
      logic       copy_start;
      logic       copy_rd;
      logic       copy_wr;
      logic       word_next;
      logic       fill;
      logic       hit_stamp;
      logic       stream_rd;
      logic       rsp_load;
      status_type rsp_status;
      logic       rsp_data;
      logic       rsp_last;
   } dp_cmd_type;

   typedef struct packed {
      logic enabled;
      logic match;
      logic cur_valid;
      logic e_last;
      logic w_last;
      logic rsp_done;
   } dp_stat_type;

endpackage

@@ src/lbc_ctrl.sv @@
module lbc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_command,
   input  logic                 req_last_word,
   output logic                 req_stall,
   input  lbc_pkg::dp_stat_type stat,
   output lbc_pkg::dp_cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_SCAN_RD   = 9'b000000010,
      S_SCAN_CHK  = 9'b000000100,
      S_COPY_RD   = 9'b000001000,
      S_COPY_WR   = 9'b000010000,
      S_FILL      = 9'b000100000,
      S_STREAM_RD = 9'b001000000,
      S_STREAM_LD = 9'b010000000,
      S_RESP      = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   lbc_pkg::cmd_type op_ff, op_in;
   logic             found_ff, found_in;
   logic             stream_ff, stream_in;
   lbc_pkg::cmd_type req_cmd;

   assign req_cmd   = lbc_pkg::cmd_type'(req_command);
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      found_in  = found_ff;
      stream_in = stream_ff;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_cmd != lbc_pkg::CMD_NONE) begin
               op_in     = req_cmd;
               found_in  = 1'b0;
               stream_in = 1'b0;
               if (!stat.enabled) begin
                  cmd.stage_clr  = 1'b1;
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = lbc_pkg::ST_OFF;
                  cmd.rsp_last   = 1'b1;
                  state_in       = S_RESP;
               end else if (req_cmd == lbc_pkg::CMD_LOOKUP) begin
                  cmd.key_load   = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN_RD;
               end else begin
                  cmd.stage_wr = 1'b1;
                  if (req_last_word) begin
                     cmd.key_load   = 1'b1;
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN_RD;
                  end
               end
            end
         end
         S_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            case (op_ff)
               lbc_pkg::CMD_LOOKUP: begin
                  if (stat.match) begin
                     cmd.hit_stamp  = 1'b1;
                     cmd.tgt_cur    = 1'b1;
                     cmd.copy_start = 1'b1;
                     stream_in      = 1'b1;
                     state_in       = S_STREAM_RD;
                  end else if (stat.e_last) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = lbc_pkg::ST_MISS;
                     cmd.rsp_last   = 1'b1;
                     state_in       = S_RESP;
                  end else begin
                     cmd.scan_next = 1'b1;
                     state_in      = S_SCAN_RD;
                  end
               end
               lbc_pkg::CMD_INSERT: begin
                  if (stat.match) begin
                     cmd.stage_clr  = 1'b1;
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = lbc_pkg::ST_PRESENT;
                     cmd.rsp_last   = 1'b1;
                     state_in       = S_RESP;
                  end else if (!stat.cur_valid) begin
                     cmd.tgt_cur    = 1'b1;
                     cmd.copy_start = 1'b1;
                     state_in       = S_COPY_RD;
                  end else if (stat.e_last) begin
                     cmd.tgt_old    = 1'b1;
                     cmd.copy_start = 1'b1;
                     state_in       = S_COPY_RD;
                  end else begin
                     cmd.track     = 1'b1;
                     cmd.scan_next = 1'b1;
                     state_in      = S_SCAN_RD;
                  end
               end
               default: begin
                  if (stat.match) begin
                     cmd.tgt_cur    = 1'b1;
                     cmd.copy_start = 1'b1;
                     found_in       = 1'b1;
                     state_in       = S_COPY_RD;
                  end else if (stat.e_last) begin
                     cmd.stage_clr  = 1'b1;
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = found_ff ? lbc_pkg::ST_OK : lbc_pkg::ST_MISS;
                     cmd.rsp_last   = 1'b1;
                     state_in       = S_RESP;
                  end else begin
                     cmd.scan_next = 1'b1;
                     state_in      = S_SCAN_RD;
                  end
               end
            endcase
         end
         S_COPY_RD: begin
            cmd.copy_rd = 1'b1;
            state_in    = S_COPY_WR;
         end
         S_COPY_WR: begin
            cmd.copy_wr = 1'b1;
            if (stat.w_last) begin
               state_in = S_FILL;
            end else begin
               cmd.word_next = 1'b1;
               state_in      = S_COPY_RD;
            end
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            if (op_ff == lbc_pkg::CMD_UPDATE && !stat.e_last) begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end else begin
               cmd.stage_clr  = 1'b1;
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = lbc_pkg::ST_OK;
               cmd.rsp_last   = 1'b1;
               state_in       = S_RESP;
            end
         end
         S_STREAM_RD: begin
            cmd.stream_rd = 1'b1;
            state_in      = S_STREAM_LD;
         end
         S_STREAM_LD: begin
            cmd.rsp_load   = 1'b1;
            cmd.rsp_status = lbc_pkg::ST_OK;
            cmd.rsp_data   = 1'b1;
            cmd.rsp_last   = stat.w_last;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (stat.rsp_done) begin
               if (stream_ff && !stat.w_last) begin
                  cmd.word_next = 1'b1;
                  state_in      = S_STREAM_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         op_ff     <= lbc_pkg::CMD_LOOKUP;
         found_ff  <= 1'b0;
         stream_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         op_ff     <= op_in;
         found_ff  <= found_in;
         stream_ff <= stream_in;
      end
   end

endmodule

@@ src/lbc_dp.sv @@
module lbc_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lbc_pkg::dp_cmd_type                    cmd,
   output lbc_pkg::dp_stat_type                   stat,
   input  logic [3:0]                             req_disk_number,
   input  logic [7:0]                             req_block_number,
   input  logic [lbc_pkg::DataW-1:0]              req_data_word,
   input  logic                                   csr_wr_en,
   input  logic                                   csr_index,
   input  logic [lbc_pkg::EntriesCfgW-1:0]        csr_wdata,
   input  logic                                   rsp_stall,
   output logic                                   rsp_valid,
   output logic [1:0]                             rsp_status,
   output logic [lbc_pkg::DataW-1:0]              rsp_read_word,
   output logic                                   rsp_last_result
);

   logic                                enabled_ff;
   logic [lbc_pkg::EntriesCfgW-1:0]     n_ff, n_in;
   logic [lbc_pkg::MaxEntries-1:0]      valid_ff;
   logic [lbc_pkg::StageCntW-1:0]       cnt_ff;
   logic [lbc_pkg::DataW-1:0]           stage_mem [lbc_pkg::BlockWords];
   logic [lbc_pkg::KeyW-1:0]            key_mem   [lbc_pkg::MaxEntries];
   logic [lbc_pkg::StampW-1:0]          stamp_mem [lbc_pkg::MaxEntries];
   logic [lbc_pkg::DataW-1:0]           bs_mem    [lbc_pkg::MaxEntries * lbc_pkg::BlockWords];
   logic [lbc_pkg::StampW-1:0]          counter_ff, counter_inc;
   logic [lbc_pkg::KeyW-1:0]            key_ff;
   logic [lbc_pkg::EntryW-1:0]          e_ff, tgt_ff, old_ff, old_pick;
   logic [lbc_pkg::WordIdxW-1:0]        w_ff;
   logic [lbc_pkg::StampW-1:0]          old_stamp_ff;
   logic [lbc_pkg::KeyW-1:0]            key_rd_ff;
   logic [lbc_pkg::StampW-1:0]          stamp_rd_ff;
   logic [lbc_pkg::DataW-1:0]           stage_rd_ff, bs_rd_ff;
   logic                                stage_ok_ff;
   logic                                rsp_valid_ff;
   lbc_pkg::status_type                 rsp_status_ff;
   logic [lbc_pkg::DataW-1:0]           rsp_word_ff;
   logic                                rsp_last_ff;
   logic                                older;
   logic [lbc_pkg::EntryW-1:0]          stamp_addr;
   logic                                enable_rise;

   assign counter_inc = counter_ff + 1'b1;
   assign enable_rise = csr_wr_en && csr_index == lbc_pkg::CSR_ENABLE && csr_wdata[0]
                        && !enabled_ff;

   // every key fits: the 4-bit disk and 8-bit block fields fill the 12-bit key
   assign stat.enabled   = enabled_ff;
   assign stat.cur_valid = valid_ff[e_ff];
   assign stat.match     = valid_ff[e_ff] && key_rd_ff == key_ff;
   assign stat.e_last    = {1'b0, e_ff} == n_ff - 1'b1;
   assign stat.w_last    = w_ff == lbc_pkg::WordIdxW'(lbc_pkg::BlockWords - 1);
   assign stat.rsp_done  = rsp_valid_ff && !rsp_stall;

   // oldest valid entry so far, lowest index on ties
   assign older    = (e_ff == '0) || (stamp_rd_ff < old_stamp_ff);
   assign old_pick = older ? e_ff : old_ff;

   always_comb begin
      n_in = csr_wdata;
      if (csr_wdata < lbc_pkg::EntriesCfgW'(lbc_pkg::MinEntries))
         n_in = lbc_pkg::EntriesCfgW'(lbc_pkg::MinEntries);
      else if (csr_wdata > lbc_pkg::EntriesCfgW'(lbc_pkg::MaxEntries))
         n_in = lbc_pkg::EntriesCfgW'(lbc_pkg::MaxEntries);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         n_ff         <= lbc_pkg::EntriesCfgW'(lbc_pkg::MinEntries);
         valid_ff     <= '0;
         cnt_ff       <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == lbc_pkg::CSR_ENABLE)
               enabled_ff <= csr_wdata[0];
            else
               n_ff <= n_in;
         end
         if (enable_rise) begin
            valid_ff <= '0;
         end else if (cmd.fill) begin
            valid_ff[tgt_ff] <= 1'b1;
         end
         if (enable_rise || cmd.stage_clr) begin
            cnt_ff <= '0;
         end else if (cmd.stage_wr &&
                      cnt_ff < lbc_pkg::StageCntW'(lbc_pkg::BlockWords)) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.fill || cmd.hit_stamp)
            counter_ff <= counter_inc;
         if (cmd.rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (stat.rsp_done)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.key_load)
         key_ff <= {req_disk_number, req_block_number};
      if (cmd.scan_start)
         e_ff <= '0;
      else if (cmd.scan_next)
         e_ff <= e_ff + 1'b1;
      if (cmd.track) begin
         old_ff       <= old_pick;
         old_stamp_ff <= older ? stamp_rd_ff : old_stamp_ff;
      end
      if (cmd.tgt_cur)
         tgt_ff <= e_ff;
      else if (cmd.tgt_old)
         tgt_ff <= old_pick;
      if (cmd.copy_start)
         w_ff <= '0;
      else if (cmd.word_next)
         w_ff <= w_ff + 1'b1;
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_word_ff   <= cmd.rsp_data ? bs_rd_ff : '0;
         rsp_last_ff   <= cmd.rsp_last;
      end
   end

   // staging buffer: words at or past the fill count read as zero
   always_ff @(posedge clock) begin
      if (cmd.stage_wr && cnt_ff < lbc_pkg::StageCntW'(lbc_pkg::BlockWords))
         stage_mem[cnt_ff[lbc_pkg::WordIdxW-1:0]] <= req_data_word;
      if (cmd.copy_rd) begin
         stage_rd_ff <= stage_mem[w_ff];
         stage_ok_ff <= {1'b0, w_ff} < cnt_ff;
      end
   end

   assign stamp_addr = cmd.hit_stamp ? e_ff : tgt_ff;

   always_ff @(posedge clock) begin
      if (cmd.fill)
         key_mem[tgt_ff] <= key_ff;
      if (cmd.fill || cmd.hit_stamp)
         stamp_mem[stamp_addr] <= counter_inc;
      if (cmd.scan_rd) begin
         key_rd_ff   <= key_mem[e_ff];
         stamp_rd_ff <= stamp_mem[e_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.copy_wr)
         bs_mem[{tgt_ff, w_ff}] <= stage_ok_ff ? stage_rd_ff : '0;
      if (cmd.stream_rd)
         bs_rd_ff <= bs_mem[{tgt_ff, w_ff}];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_word   = rsp_word_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

@@ src/lru_block_cache.sv @@
// Fully associative block cache of 64 entries of 32 64-bit words, keyed by disk and block
// number, least-recently-used replacement by a 32-bit wrapping stamp. One item at a time:
// every command on an enabled cache scans the configured entries through the key/stamp
// memories, reading and then checking each entry. A lookup hit then streams its 32 words,
// each read from the store and held as a result through any output stall. An insert or
// update copies the staged block into the store word by word, read then write, and then
// stamps each entry it writes. Data words of an insert or update that are not marked last
// are taken without a stall. Enabling clears all valid marks at once; no clearing pass.
module lru_block_cache (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_command,
   input  logic [3:0]                          req_disk_number,
   input  logic [7:0]                          req_block_number,
   input  logic [lbc_pkg::DataW-1:0]           req_data_word,
   input  logic                                req_last_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [lbc_pkg::DataW-1:0]           rsp_read_word,
   output logic                                rsp_last_result,
   input  logic                                csr_wr_en,
   input  logic                                csr_index,
   input  logic [lbc_pkg::EntriesCfgW-1:0]     csr_wdata
);

   lbc_pkg::dp_cmd_type  cmd;
   lbc_pkg::dp_stat_type stat;

   lbc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_command   (req_command),
      .req_last_word (req_last_word),
      .req_stall     (req_stall),
      .stat          (stat),
      .cmd           (cmd)
   );

   lbc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_disk_number  (req_disk_number),
      .req_block_number (req_block_number),
      .req_data_word    (req_data_word),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_read_word    (rsp_read_word),
      .rsp_last_result  (rsp_last_result)
   );

`ifndef NO_ASSERTIONS
   // a new item is taken only once every result of the previous one is gone
   assert property (@(posedge clock) disable iff (reset) !req_stall |-> !rsp_valid)
      else $error("item accepted while a result is pending");

   // only a lookup hit gives results that are not final, and those all report a hit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> rsp_status == lbc_pkg::ST_OK)
      else $error("non-final result without hit status");

   // block data only travels with a hit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lbc_pkg::ST_OK |-> rsp_read_word == '0)
      else $error("data word on a non-hit result");
`endif

endmodule
